// ----- src/cps_pkg.sv -----
// shared types and constants for the segment closest-point engine
package cps_pkg;

	// digit width of the partial-product operands in the pipelined multipliers
	localparam int MUL_DIGIT = 32;

	// how a result coordinate is formed
	typedef enum logic [1:0] {
		MODE_START,
		MODE_END,
		MODE_ALONG
	} pt_mode_t;

	// register stages through cps_mul for given operand widths
	function automatic int mul_latency(input int aw, input int bw);
		int na;
		int nb;
		na = (aw + MUL_DIGIT - 1) / MUL_DIGIT;
		nb = (bw + MUL_DIGIT - 1) / MUL_DIGIT;
		return na * nb + 2;
	endfunction

endpackage

// ----- src/closest_points_between_segments.sv -----
// top level: closest points between two 3d segments, fully pipelined
//
// channel   direction  transfer marked by     payload
// input     in         start && !busy         seg0/seg1 start and end, x y z
// result    out        done (one cycle)       valid_res, near0_x..near1_z
//
// an item enters every cycle; busy is held low since nothing in the pipe ever waits
// data pass stages 1 to 3, the first multiplier bank, stages 4 to 6, the second bank,
// stages 7 and 8, the COORD_BITS divider stages, then stages 9 and 10
// reset clears only the valid bits; the data registers run free
// the receiver cannot stall, so each result is shown for exactly one cycle
module closest_points_between_segments #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_BITS-1:0] seg0_start_x,
	input  logic signed [COORD_BITS-1:0] seg0_start_y,
	input  logic signed [COORD_BITS-1:0] seg0_start_z,
	input  logic signed [COORD_BITS-1:0] seg0_end_x,
	input  logic signed [COORD_BITS-1:0] seg0_end_y,
	input  logic signed [COORD_BITS-1:0] seg0_end_z,
	input  logic signed [COORD_BITS-1:0] seg1_start_x,
	input  logic signed [COORD_BITS-1:0] seg1_start_y,
	input  logic signed [COORD_BITS-1:0] seg1_start_z,
	input  logic signed [COORD_BITS-1:0] seg1_end_x,
	input  logic signed [COORD_BITS-1:0] seg1_end_y,
	input  logic signed [COORD_BITS-1:0] seg1_end_z,
	output logic done,
	output logic valid_res,
	output logic signed [COORD_BITS-1:0] near0_x,
	output logic signed [COORD_BITS-1:0] near0_y,
	output logic signed [COORD_BITS-1:0] near0_z,
	output logic signed [COORD_BITS-1:0] near1_x,
	output logic signed [COORD_BITS-1:0] near1_y,
	output logic signed [COORD_BITS-1:0] near1_z
);
	import cps_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int VW  = CB + 1;          // segment directions and offset
	localparam int PRW = 2 * VW;          // one coordinate product
	localparam int DW  = 2 * CB + 3;      // dot products
	localparam int QDW = DW + 1;          // projection numerators
	localparam int PW  = 2 * DW + 1;      // determinant and solved numerators
	localparam int NW  = VW + PW;         // direction times numerator
	localparam int QW  = CB;              // rounded offset magnitude
	localparam int LM1 = mul_latency(DW, DW);
	localparam int LM2 = mul_latency(VW, PW);
	localparam int L   = 10 + LM1 + LM2 + QW;

	typedef struct packed {
		logic [2:0][CB-1:0] a0;
		logic [2:0][CB-1:0] b0;
		logic [2:0][CB-1:0] a1;
		logic [2:0][CB-1:0] b1;
	} crd_t;

	typedef struct packed {
		crd_t               crd;
		logic [2:0][VW-1:0] u;
		logic [2:0][VW-1:0] v;
	} geo_t;

	typedef struct packed {
		geo_t          g;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] c;
		logic [DW-1:0] d;
		logic [DW-1:0] e;
	} m1_t;

	typedef struct packed {
		crd_t          crd;
		pt_mode_t      mode0;
		pt_mode_t      mode1;
		logic [PW-1:0] den0;
		logic [PW-1:0] den1;
		logic          ok;
	} m2_t;

	typedef struct packed {
		crd_t     crd;
		pt_mode_t mode0;
		pt_mode_t mode1;
		logic     ok;
		logic [5:0] neg;
	} fin_t;

	// input transfer and valid bits
	logic [L-1:0] vld_q;

	assign busy = 1'b0;
	assign done = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[L-2:0], start & ~busy};
		end
	end

	// stage 1: directions u = b0 - a0, v = b1 - a1, offset w = a1 - a0
	logic [2:0][CB-1:0] a0_in, b0_in, a1_in, b1_in;
	logic [2:0][VW-1:0] u_in, v_in, w_in;
	geo_t               geo_s1;
	logic [2:0][VW-1:0] w_s1;

	assign a0_in = {seg0_start_z, seg0_start_y, seg0_start_x};
	assign b0_in = {seg0_end_z, seg0_end_y, seg0_end_x};
	assign a1_in = {seg1_start_z, seg1_start_y, seg1_start_x};
	assign b1_in = {seg1_end_z, seg1_end_y, seg1_end_x};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u_in[k] = VW'($signed(b0_in[k])) - VW'($signed(a0_in[k]));
			v_in[k] = VW'($signed(b1_in[k])) - VW'($signed(a1_in[k]));
			w_in[k] = VW'($signed(a1_in[k])) - VW'($signed(a0_in[k]));
		end
	end

	always_ff @(posedge clk) begin
		geo_s1.crd.a0 <= a0_in;
		geo_s1.crd.b0 <= b0_in;
		geo_s1.crd.a1 <= a1_in;
		geo_s1.crd.b1 <= b1_in;
		geo_s1.u      <= u_in;
		geo_s1.v      <= v_in;
		w_s1          <= w_in;
	end

	// stage 2: the fifteen coordinate products
	logic [2:0][PRW-1:0] uu_s2, uv_s2, vv_s2, uw_s2, vw_s2;
	geo_t                geo_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			uu_s2[k] <= $signed(geo_s1.u[k]) * $signed(geo_s1.u[k]);
			uv_s2[k] <= $signed(geo_s1.u[k]) * $signed(geo_s1.v[k]);
			vv_s2[k] <= $signed(geo_s1.v[k]) * $signed(geo_s1.v[k]);
			uw_s2[k] <= $signed(geo_s1.u[k]) * $signed(w_s1[k]);
			vw_s2[k] <= $signed(geo_s1.v[k]) * $signed(w_s1[k]);
		end
		geo_s2 <= geo_s1;
	end

	// stage 3: dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
	m1_t m1_s3;

	always_ff @(posedge clk) begin
		m1_s3.g <= geo_s2;
		m1_s3.a <= DW'($signed(uu_s2[0])) + DW'($signed(uu_s2[1])) + DW'($signed(uu_s2[2]));
		m1_s3.b <= DW'($signed(uv_s2[0])) + DW'($signed(uv_s2[1])) + DW'($signed(uv_s2[2]));
		m1_s3.c <= DW'($signed(vv_s2[0])) + DW'($signed(vv_s2[1])) + DW'($signed(vv_s2[2]));
		m1_s3.d <= DW'($signed(uw_s2[0])) + DW'($signed(uw_s2[1])) + DW'($signed(uw_s2[2]));
		m1_s3.e <= DW'($signed(vw_s2[0])) + DW'($signed(vw_s2[1])) + DW'($signed(vw_s2[2]));
	end

	// first multiplier bank: the 2x2 determinant and the solved numerators
	logic [2*DW-1:0] ac_p, bb_p, cd_p, be_p, bd_p, ae_p;

	cps_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk(clk), .a(m1_s3.a), .b(m1_s3.c), .p(ac_p));
	cps_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk(clk), .a(m1_s3.b), .b(m1_s3.b), .p(bb_p));
	cps_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk(clk), .a(m1_s3.c), .b(m1_s3.d), .p(cd_p));
	cps_mul #(.AW(DW), .BW(DW)) u_mul_be (.clk(clk), .a(m1_s3.b), .b(m1_s3.e), .p(be_p));
	cps_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clk(clk), .a(m1_s3.b), .b(m1_s3.d), .p(bd_p));
	cps_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clk(clk), .a(m1_s3.a), .b(m1_s3.e), .p(ae_p));

	// side data rides along with the multiplier bank
	m1_t m1_d [LM1];

	always_ff @(posedge clk) begin
		m1_d[0] <= m1_s3;
		for (int i = 1; i < LM1; i++) begin
			m1_d[i] <= m1_d[i-1];
		end
	end

	// stage 4: den = ac - bb, ns = cd - be, nr = bd - ae
	logic [PW-1:0] den_s4, ns_s4, nr_s4;
	m1_t           m1_s4;

	always_ff @(posedge clk) begin
		den_s4 <= PW'($signed(ac_p)) - PW'($signed(bb_p));
		ns_s4  <= PW'($signed(cd_p)) - PW'($signed(be_p));
		nr_s4  <= PW'($signed(bd_p)) - PW'($signed(ae_p));
		m1_s4  <= m1_d[LM1-1];
	end

	// stage 5: range flags, projection numerators for the clamped cases
	logic [PW:0]    dms, dmr;
	logic           den_pos_s5, s_neg_s5, s_hi_s5, r_neg_s5, r_hi_s5;
	logic [QDW-1:0] q0_s5, q1_s5;
	logic [PW-1:0]  den_s5, ns_s5, nr_s5;
	logic [DW-1:0]  a_s5, c_s5;
	geo_t           geo_s5;

	assign dms = (PW+1)'($signed(den_s4)) - (PW+1)'($signed(ns_s4));
	assign dmr = (PW+1)'($signed(den_s4)) - (PW+1)'($signed(nr_s4));

	always_ff @(posedge clk) begin
		den_pos_s5 <= ~den_s4[PW-1] & (den_s4 != '0);
		s_neg_s5   <= ns_s4[PW-1];
		s_hi_s5    <= dms[PW];
		r_neg_s5   <= nr_s4[PW-1];
		r_hi_s5    <= dmr[PW];
		// point 1 projected from a0 gives -e, from b0 gives b - e
		q1_s5 <= ns_s4[PW-1] ? QDW'(-$signed(QDW'($signed(m1_s4.e))))
		                     : QDW'($signed(m1_s4.b)) - QDW'($signed(m1_s4.e));
		// point 0 projected from a1 gives d, from b1 gives b + d
		q0_s5 <= nr_s4[PW-1] ? QDW'($signed(m1_s4.d))
		                     : QDW'($signed(m1_s4.b)) + QDW'($signed(m1_s4.d));
		den_s5 <= den_s4;
		ns_s5  <= ns_s4;
		nr_s5  <= nr_s4;
		a_s5   <= m1_s4.a;
		c_s5   <= m1_s4.c;
		geo_s5 <= m1_s4.g;
	end

	// stage 6: pick how each point is formed and its fraction num / den
	logic          s_out, r_out;
	logic          q0_le0, q0_ge, q1_le0, q1_ge;
	pt_mode_t      mode0_c, mode1_c;
	logic [PW-1:0] num0_c, num1_c, den0_c, den1_c;

	always_comb begin
		s_out  = s_neg_s5 | s_hi_s5;
		r_out  = r_neg_s5 | r_hi_s5;
		q0_le0 = q0_s5[QDW-1] | (q0_s5 == '0);
		q1_le0 = q1_s5[QDW-1] | (q1_s5 == '0);
		q0_ge  = $signed(q0_s5) >= $signed(QDW'($signed(a_s5)));
		q1_ge  = $signed(q1_s5) >= $signed(QDW'($signed(c_s5)));

		mode0_c = MODE_ALONG;
		num0_c  = ns_s5;
		den0_c  = den_s5;
		mode1_c = MODE_ALONG;
		num1_c  = nr_s5;
		den1_c  = den_s5;

		if (s_out) begin
			// point 0 clamps to an end, point 1 is its projection
			mode0_c = s_neg_s5 ? MODE_START : MODE_END;
			num1_c  = PW'($signed(q1_s5));
			den1_c  = PW'($signed(c_s5));
			if (q1_le0) begin
				mode1_c = MODE_START;
			end else if (q1_ge) begin
				mode1_c = MODE_END;
			end
		end else if (r_out) begin
			// roles swapped
			mode1_c = r_neg_s5 ? MODE_START : MODE_END;
			num0_c  = PW'($signed(q0_s5));
			den0_c  = PW'($signed(a_s5));
			if (q0_le0) begin
				mode0_c = MODE_START;
			end else if (q0_ge) begin
				mode0_c = MODE_END;
			end
		end
	end

	logic [PW-1:0] num0_s6, num1_s6;
	m2_t           m2_s6;
	geo_t          geo_s6;

	always_ff @(posedge clk) begin
		num0_s6     <= num0_c;
		num1_s6     <= num1_c;
		m2_s6.crd   <= geo_s5.crd;
		m2_s6.mode0 <= mode0_c;
		m2_s6.mode1 <= mode1_c;
		m2_s6.den0  <= den0_c;
		m2_s6.den1  <= den1_c;
		m2_s6.ok    <= den_pos_s5;
		geo_s6      <= geo_s5;
	end

	// second multiplier bank: direction times numerator, per coordinate
	logic [5:0][NW-1:0] dn_p;

	for (genvar k = 0; k < 3; k++) begin : g_dn
		cps_mul #(.AW(VW), .BW(PW)) u_mul_p0 (
			.clk(clk), .a(geo_s6.u[k]), .b(num0_s6), .p(dn_p[k])
		);
		cps_mul #(.AW(VW), .BW(PW)) u_mul_p1 (
			.clk(clk), .a(geo_s6.v[k]), .b(num1_s6), .p(dn_p[k+3])
		);
	end

	m2_t m2_d [LM2];

	always_ff @(posedge clk) begin
		m2_d[0] <= m2_s6;
		for (int i = 1; i < LM2; i++) begin
			m2_d[i] <= m2_d[i-1];
		end
	end

	// stage 7: magnitude of each product, sign kept aside
	logic [5:0]         neg_s7;
	logic [5:0][NW-1:0] mag_s7;
	m2_t                m2_s7;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			neg_s7[k] <= dn_p[k][NW-1];
			mag_s7[k] <= dn_p[k][NW-1] ? NW'(-dn_p[k]) : dn_p[k];
		end
		m2_s7 <= m2_d[LM2-1];
	end

	// stage 8: round to nearest as (2m + den) / (2 den)
	logic [5:0][NW+1:0] nn_s8;
	logic [PW:0]        dd0_s8, dd1_s8;
	fin_t               fin_s8;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			nn_s8[k] <= {1'b0, mag_s7[k], 1'b0}
			          + (NW+2)'(k < 3 ? m2_s7.den0 : m2_s7.den1);
		end
		dd0_s8       <= {m2_s7.den0, 1'b0};
		dd1_s8       <= {m2_s7.den1, 1'b0};
		fin_s8.crd   <= m2_s7.crd;
		fin_s8.mode0 <= m2_s7.mode0;
		fin_s8.mode1 <= m2_s7.mode1;
		fin_s8.ok    <= m2_s7.ok;
		fin_s8.neg   <= neg_s7;
	end

	// divider bank
	logic [5:0][QW-1:0] quo;

	for (genvar k = 0; k < 6; k++) begin : g_div
		cps_div #(.NW(NW+2), .DW(PW+1), .QW(QW)) u_div (
			.clk(clk),
			.n  (nn_s8[k]),
			.d  (k < 3 ? dd0_s8 : dd1_s8),
			.q  (quo[k])
		);
	end

	fin_t fin_d [QW];

	always_ff @(posedge clk) begin
		fin_d[0] <= fin_s8;
		for (int i = 1; i < QW; i++) begin
			fin_d[i] <= fin_d[i-1];
		end
	end

	// stage 9: signed offset along the segment
	logic [5:0][CB:0] off_s9;
	fin_t             fin_s9;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			off_s9[k] <= fin_d[QW-1].neg[k] ? (CB+1)'(-{1'b0, quo[k]}) : {1'b0, quo[k]};
		end
		fin_s9 <= fin_d[QW-1];
	end

	// stage 10: base plus offset, saturate, select endpoint or zero
	logic [5:0][CB-1:0] base_c, endp_c, res_c;
	logic [5:0][CB+1:0] sum_c;
	pt_mode_t           mode_c [6];
	logic [5:0][CB-1:0] out_s10;
	logic               ok_s10;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			if (k < 3) begin
				base_c[k] = fin_s9.crd.a0[k];
				endp_c[k] = fin_s9.crd.b0[k];
				mode_c[k] = fin_s9.mode0;
			end else begin
				base_c[k] = fin_s9.crd.a1[k-3];
				endp_c[k] = fin_s9.crd.b1[k-3];
				mode_c[k] = fin_s9.mode1;
			end
			sum_c[k] = (CB+2)'($signed(base_c[k])) + (CB+2)'($signed(off_s9[k]));
			if (sum_c[k][CB+1:CB-1] == 3'b000 || sum_c[k][CB+1:CB-1] == 3'b111) begin
				res_c[k] = sum_c[k][CB-1:0];
			end else if (sum_c[k][CB+1]) begin
				res_c[k] = {1'b1, {(CB-1){1'b0}}};
			end else begin
				res_c[k] = {1'b0, {(CB-1){1'b1}}};
			end
			if (!fin_s9.ok) begin
				res_c[k] = '0;
			end else if (mode_c[k] == MODE_START) begin
				res_c[k] = base_c[k];
			end else if (mode_c[k] == MODE_END) begin
				res_c[k] = endp_c[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_s10 <= res_c;
		ok_s10  <= fin_s9.ok;
	end

	assign valid_res = ok_s10;
	assign near0_x   = out_s10[0];
	assign near0_y   = out_s10[1];
	assign near0_z   = out_s10[2];
	assign near1_x   = out_s10[3];
	assign near1_y   = out_s10[4];
	assign near1_z   = out_s10[5];

endmodule

// ----- src/cps_mul.sv -----
// pipelined signed multiplier, one digit pair per stage
module cps_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic          clk,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);
	import cps_pkg::*;

	localparam int NA  = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NB  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NS  = NA * NB;
	localparam int PWD = AW + BW;
	localparam int AXW = NA * MUL_DIGIT;
	localparam int BXW = NB * MUL_DIGIT;
	localparam int PPW = PWD + 2 * MUL_DIGIT;

	logic [AXW-1:0] ma_s  [NS+1];
	logic [BXW-1:0] mb_s  [NS+1];
	logic [PWD-1:0] acc_s [NS+1];
	logic           neg_s [NS+1];
	logic [AW-1:0]  a_mag;
	logic [BW-1:0]  b_mag;

	// magnitudes, sign applied again at the end
	assign a_mag = a[AW-1] ? AW'(-a) : a;
	assign b_mag = b[BW-1] ? BW'(-b) : b;

	always_ff @(posedge clk) begin
		ma_s[0]  <= AXW'(a_mag);
		mb_s[0]  <= BXW'(b_mag);
		acc_s[0] <= '0;
		neg_s[0] <= a[AW-1] ^ b[BW-1];
	end

	for (genvar k = 0; k < NS; k++) begin : g_mac
		localparam int I  = k / NB;
		localparam int J  = k % NB;
		localparam int SH = (I + J) * MUL_DIGIT;
		logic [2*MUL_DIGIT-1:0] pp;
		logic [PPW-1:0]         ppw;
		assign pp  = ma_s[k][I*MUL_DIGIT +: MUL_DIGIT] * mb_s[k][J*MUL_DIGIT +: MUL_DIGIT];
		assign ppw = PPW'(pp) << SH;
		always_ff @(posedge clk) begin
			ma_s[k+1]  <= ma_s[k];
			mb_s[k+1]  <= mb_s[k];
			neg_s[k+1] <= neg_s[k];
			acc_s[k+1] <= acc_s[k] + ppw[PWD-1:0];
		end
	end

	always_ff @(posedge clk) begin
		p <= neg_s[NS] ? PWD'(-acc_s[NS]) : acc_s[NS];
	end

endmodule

// ----- src/cps_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module cps_div #(
	parameter int NW = 8,
	parameter int DW = 4,
	parameter int QW = 4
) (
	input  logic          clk,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q
);
	localparam int XW = NW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int B = QW - 1 - i;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [XW-1:0] trial;
		logic [XW-1:0] remw;
		logic [XW-1:0] diff;
		logic          take;
		if (i == 0) begin : g_first
			assign rem_in = n;
			assign d_in   = d;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign d_in   = d_s[i-1];
			assign q_in   = q_s[i-1];
		end
		assign trial = XW'(d_in) << B;
		assign remw  = XW'(rem_in);
		assign take  = remw >= trial;
		assign diff  = remw - trial;
		always_ff @(posedge clk) begin
			rem_s[i] <= take ? diff[NW-1:0] : rem_in;
			d_s[i]   <= d_in;
			q_s[i]   <= q_in | (QW'(take) << B);
		end
	end

	assign q = q_s[QW-1];

endmodule

// ----- verif/tb_closest_points_between_segments.sv -----
// testbench for the segment closest-point engine: directed and random pairs against a predictor
`timescale 1ns / 1ps

class seg_pair_scoreboard;
	// expected outputs packed as {valid, n0x, n0y, n0z, n1x, n1y, n1z}
	logic [192:0] pending_points[$];
	int errors;
	int n_solved;
	int n_singular;

	function new();
		errors = 0;
		n_solved = 0;
		n_singular = 0;
	endfunction

	// round(num/den), ties away from zero; den > 0
	function automatic logic signed [255:0] round_quot(input logic signed [255:0] num,
			input logic signed [255:0] den);
		logic signed [255:0] mag;
		logic signed [255:0] q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [255:0] v);
		if (v > 256'sd2147483647)
			return 32'sh7fffffff;
		if (v < -256'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// point at base + dir*num/den, one rounding per coordinate
	function automatic void walk(input logic signed [255:0] base[3],
			input logic signed [255:0] dir[3], input logic signed [255:0] num,
			input logic signed [255:0] den, output logic signed [31:0] pt[3]);
		for (int k = 0; k < 3; k++)
			pt[k] = sat32(base[k] + round_quot(dir[k] * num, den));
	endfunction

	// nearest point to p on the segment base..base+dir, parameter clamped
	function automatic void snap(input logic signed [255:0] base[3],
			input logic signed [255:0] dir[3], input logic signed [255:0] len2,
			input logic signed [255:0] p[3], output logic signed [31:0] pt[3]);
		logic signed [255:0] q;
		q = 0;
		for (int k = 0; k < 3; k++)
			q += (p[k] - base[k]) * dir[k];
		if (q <= 0) begin
			for (int k = 0; k < 3; k++) pt[k] = base[k][31:0];
		end else if (q >= len2) begin
			for (int k = 0; k < 3; k++) pt[k] = sat32(base[k] + dir[k]);
		end else begin
			walk(base, dir, q, len2, pt);
		end
	endfunction

	// crd: a0 xyz, b0 xyz, a1 xyz, b1 xyz
	function void note_pair(input logic signed [31:0] crd[12]);
		logic signed [255:0] a0[3], b0[3], a1[3], b1[3], u[3], v[3], w[3], p[3];
		logic signed [255:0] a, b, c, d, e, den, ns, nr;
		logic signed [31:0] n0[3], n1[3];
		a = 0; b = 0; c = 0; d = 0; e = 0;
		for (int k = 0; k < 3; k++) begin
			a0[k] = crd[k]; b0[k] = crd[3 + k]; a1[k] = crd[6 + k]; b1[k] = crd[9 + k];
			u[k] = b0[k] - a0[k]; v[k] = b1[k] - a1[k]; w[k] = a1[k] - a0[k];
		end
		for (int k = 0; k < 3; k++) begin
			a += u[k] * u[k]; b += u[k] * v[k]; c += v[k] * v[k];
			d += u[k] * w[k]; e += v[k] * w[k];
		end
		den = a * c - b * b;
		if (den <= 0) begin
			pending_points.push_back('0);
			n_singular++;
			return;
		end
		ns = c * d - b * e;
		nr = b * d - a * e;
		if (ns < 0 || ns > den) begin
			for (int k = 0; k < 3; k++) begin
				n0[k] = (ns < 0) ? crd[k] : crd[3 + k];
				p[k] = n0[k];
			end
			snap(a1, v, c, p, n1);
		end else if (nr < 0 || nr > den) begin
			for (int k = 0; k < 3; k++) begin
				n1[k] = (nr < 0) ? crd[6 + k] : crd[9 + k];
				p[k] = n1[k];
			end
			snap(a0, u, a, p, n0);
		end else begin
			walk(a0, u, ns, den, n0);
			walk(a1, v, nr, den, n1);
		end
		n_solved++;
		pending_points.push_back({1'b1, n0[0], n0[1], n0[2], n1[0], n1[1], n1[2]});
	endfunction

	function void check_result(input logic [192:0] got);
		logic [192:0] exp_pts;
		string names[7] = '{"near1_z", "near1_y", "near1_x", "near0_z", "near0_y",
			"near0_x", "valid_res"};
		if (pending_points.size() == 0) begin
			$error("result with no pair outstanding: %h", got);
			errors++;
			return;
		end
		exp_pts = pending_points.pop_front();
		if (exp_pts[192] !== got[192]) begin
			$error("valid_res expected %0d got %0d", exp_pts[192], got[192]);
			errors++;
		end
		for (int f = 0; f < 6; f++)
			if (exp_pts[f*32 +: 32] !== got[f*32 +: 32]) begin
				$error("%s expected %0d got %0d", names[f],
					$signed(exp_pts[f*32 +: 32]), $signed(got[f*32 +: 32]));
				errors++;
			end
	endfunction
endclass

module tb_closest_points_between_segments;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, valid_res;
	logic signed [31:0] crd[12];
	logic signed [31:0] near0_x, near0_y, near0_z, near1_x, near1_y, near1_z;

	seg_pair_scoreboard sb = new();
	int idle_cycles;
	int sender_idle_pct;
	bit timed_out;

	initial for (int k = 0; k < 12; k++) crd[k] = '0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	closest_points_between_segments uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg0_start_x(crd[0]), .seg0_start_y(crd[1]), .seg0_start_z(crd[2]),
		.seg0_end_x(crd[3]), .seg0_end_y(crd[4]), .seg0_end_z(crd[5]),
		.seg1_start_x(crd[6]), .seg1_start_y(crd[7]), .seg1_start_z(crd[8]),
		.seg1_end_x(crd[9]), .seg1_end_y(crd[10]), .seg1_end_z(crd[11]),
		.done(done), .valid_res(valid_res),
		.near0_x(near0_x), .near0_y(near0_y), .near0_z(near0_z),
		.near1_x(near1_x), .near1_y(near1_y), .near1_z(near1_z)
	);

	// monitor: a transfer on either side happens at the rising edge; sample the old values
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pair(crd);
			if (done)
				sb.check_result({valid_res, near0_x, near0_y, near0_z,
					near1_x, near1_y, near1_z});
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog on cycles with no transfer at all
	initial begin
		idle_cycles = 0;
		timed_out = 0;
		wait (idle_cycles >= WATCHDOG_LIMIT);
		timed_out = 1;
		$display("closest_points_between_segments test failed");
		$finish;
	end

	// present one pair and hold it until the block takes it
	task automatic send_pair(input logic signed [31:0] v[12]);
		while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		for (int k = 0; k < 12; k++) crd[k] <= v[k];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// coordinates: sometimes full range, mostly modest so interior solutions show up
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9, 0))
			0, 1: return $urandom();
			2: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(2000000, 0)) - 32'sd1000000;
		endcase
	endfunction

	task automatic send_random(input int count);
		logic signed [31:0] v[12];
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 12; k++) v[k] = rand_coord();
			case ($urandom_range(7, 0))
				0: for (int k = 0; k < 3; k++) v[9 + k] = v[6 + k] + 2 * (v[3 + k] - v[k]);
				1: for (int k = 0; k < 3; k++) v[3 + k] = v[k];
				default: ;
			endcase
			send_pair(v);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending_points.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] v[12];
		sender_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// skew segments at right angles: interior solution
		v = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536};
		send_pair(v);
		// s below 0 and above 1, r then found by projection
		v = '{0, 0, 0, 65536, 0, 0, -300000, -65536, 0, -300000, 65536, 9};
		send_pair(v);
		v = '{0, 0, 0, 65536, 0, 0, 300000, -65536, 0, 300000, 65536, 9};
		send_pair(v);
		// r outside with s inside
		v = '{-65536, 0, 0, 65536, 0, 0, 0, 100000, 5, 0, 400000, 5};
		send_pair(v);
		v = '{-65536, 0, 0, 65536, 0, 0, 0, -400000, 5, 0, -100000, 5};
		send_pair(v);
		// parallel, zero-length, all zero
		v = '{0, 0, 0, 65536, 0, 0, 0, 5, 0, 65536, 5, 0};
		send_pair(v);
		v = '{7, 7, 7, 7, 7, 7, 0, 0, 0, 65536, 1, 2};
		send_pair(v);
		for (int k = 0; k < 12; k++) v[k] = 0;
		send_pair(v);
		// extremes of every field
		for (int k = 0; k < 12; k++) v[k] = k[0] ? 32'sh7fffffff : 32'sh80000000;
		send_pair(v);
		for (int k = 0; k < 12; k++) v[k] = (k % 3 == 1) ? 32'sh80000000 : 32'sh7fffffff;
		send_pair(v);
		for (int k = 0; k < 12; k++) v[k] = (k < 6) ? -1 : ((k % 2) ? 32'sh7fffffff : 1);
		send_pair(v);
		v = '{32'sh80000000, 0, 1, 32'sh7fffffff, 1, 0, 0, 32'sh80000000, 32'sh7fffffff,
			1, 32'sh7fffffff, 32'sh80000000};
		send_pair(v);

		// back to back, then pause until the pipe drains
		send_random(100);
		start <= 1'b0;
		wait_drained();
		sender_idle_pct = 52;
		send_random(100);
		sender_idle_pct = 8;
		send_random(100);
		sender_idle_pct = 0;
		send_random(100);
		start <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!timed_out) begin
			$display("covered %0d solved pairs and %0d singular pairs, %0d mismatches",
				sb.n_solved, sb.n_singular, sb.errors);
			if (sb.errors == 0 && sb.pending_points.size() == 0)
				$display("closest_points_between_segments test passed");
			else
				$display("closest_points_between_segments test failed");
			$finish;
		end
	end
endmodule

// ----- filelist.f -----
src/cps_pkg.sv
src/cps_mul.sv
src/cps_div.sv
src/closest_points_between_segments.sv
verif/tb_closest_points_between_segments.sv
